// ===== design/wheel_speed_to_motor_rpm_limiter_unit_macros.svh =====
// Assertion macros for the wheel speed to motor rpm limiter.
// Expects clk and arst_n in the including module's scope.
`ifndef WHEEL_SPEED_TO_MOTOR_RPM_LIMITER_UNIT_MACROS_SVH
`define WHEEL_SPEED_TO_MOTOR_RPM_LIMITER_UNIT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define WSRPM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check expr on every clock edge out of reset.
`define WSRPM_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// ===== design/wsrpm_pkg.sv =====
// Types and fixed constants of the wheel speed to motor rpm limiter.
// No dependencies; the top level imports it.
package wsrpm_pkg;

	localparam int SPD_W   = 24;	// wheel speed field
	localparam int RPM_W   = 16;	// rpm result field
	localparam int GEAR_W  = 16;	// gear ratio, Q8.8
	localparam int LIM_W   = 15;	// max_rpm, min_rpm
	localparam int K_W     = 24;	// 60/(2*pi) constant
	localparam int GK_W    = GEAR_W + K_W;
	localparam int M_W     = SPD_W + GK_W;	// rpm magnitude before rounding
	localparam int NUM_W   = SPD_W + LIM_W + 1;
	localparam int DEN_W   = SPD_W + 1;
	localparam int QW      = LIM_W;	// quotient bits of the ratio divide
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int GEAR_FRAC = 8;
	localparam int K_FRAC    = 20;

	// 60/(2*pi) with 20 fraction bits
	localparam logic [K_W-1:0] RPM_K = 24'd10013163;

	// register indexes
	localparam logic [2:0] REG_GEAR = 3'd0;
	localparam logic [2:0] REG_MAX  = 3'd1;
	localparam logic [2:0] REG_MIN  = 3'd2;
	localparam logic [2:0] REG_LINV = 3'd3;
	localparam logic [2:0] REG_RINV = 3'd4;

	localparam logic [GEAR_W-1:0] GEAR_RST = 16'd256;
	localparam logic [LIM_W-1:0]  MAX_RST  = 15'd3000;
	localparam logic [LIM_W-1:0]  MIN_RST  = 15'd0;
	localparam logic [GK_W-1:0]   GK_RST   = GK_W'(GEAR_RST) * GK_W'(RPM_K);

	// per-item control and magnitudes after the limit compare
	typedef struct packed {
		logic             neg_l;
		logic             neg_r;
		logic             nz_l;	// magnitude before rounding is nonzero
		logic             nz_r;
		logic             useq_l;	// take the divider quotient
		logic             useq_r;
		logic             scaled;
		logic [LIM_W-1:0] mag_l;
		logic [LIM_W-1:0] mag_r;
	} pipe_t;

	// restoring divider state
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QW-1:0]    q;
	} div_t;

endpackage

// ===== design/wheel_speed_to_motor_rpm_limiter_unit.sv =====
// Wheel speed to motor rpm limiter, top level; uses wsrpm_pkg and the macros header.
// Pipeline: 3 arithmetic stages, 15 divider stages of one quotient bit each and
// 1 output register.
// Throughput: one transfer per cycle; bubbles collapse, so a stalled output still
// lets new items enter until every stage is full.
// Reset clears the valid bits and loads the register reset values.
`include "wheel_speed_to_motor_rpm_limiter_unit_macros.svh"

module wheel_speed_to_motor_rpm_limiter_unit #(
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// speed pair in
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [wsrpm_pkg::SPD_W-1:0] left_speed,
	input  logic signed [wsrpm_pkg::SPD_W-1:0] right_speed,
	// rpm pair out
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [wsrpm_pkg::RPM_W-1:0] left_cmd,
	output logic signed [wsrpm_pkg::RPM_W-1:0] right_cmd,
	output logic                            was_scaled,
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wsrpm_pkg::ADDR_W-1:0]    paddr,
	input  logic [wsrpm_pkg::DATA_W-1:0]    pwdata,
	output logic [wsrpm_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);
	import wsrpm_pkg::*;

	// total fraction bits of the rpm magnitude
	localparam int FR   = SPEED_FRAC_BITS + GEAR_FRAC + K_FRAC;
	localparam int SUMW = M_W + 1;
	localparam logic [SUMW-1:0] HALF = SUMW'(1) << (FR - 1);
	localparam int N_ST = 3 + QW + 1;

	// ------------------------------------------------------------------
	// Registers. The gear setting times RPM_K is formed at the write, so
	// the data path needs a single multiply for the rpm magnitude.
	// ------------------------------------------------------------------
	logic [GEAR_W-1:0] gear_q;
	logic [GK_W-1:0]   gk_q;
	logic [LIM_W-1:0]  max_q;
	logic [LIM_W-1:0]  min_q;
	logic              linv_q;
	logic              rinv_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q <= GEAR_RST;
			gk_q   <= GK_RST;
			max_q  <= MAX_RST;
			min_q  <= MIN_RST;
			linv_q <= 1'b0;
			rinv_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_GEAR: begin
					gear_q <= pwdata[GEAR_W-1:0];
					gk_q   <= GK_W'(pwdata[GEAR_W-1:0]) * GK_W'(RPM_K);
				end
				REG_MAX:  max_q  <= pwdata[LIM_W-1:0];
				REG_MIN:  min_q  <= pwdata[LIM_W-1:0];
				REG_LINV: linv_q <= pwdata[0];
				REG_RINV: rinv_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GEAR: prdata = DATA_W'(gear_q);
			REG_MAX:  prdata = DATA_W'(max_q);
			REG_MIN:  prdata = DATA_W'(min_q);
			REG_LINV: prdata = DATA_W'(linv_q);
			REG_RINV: prdata = DATA_W'(rinv_q);
			default:  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. A stage advances when it or any stage after it is
	// empty, or the output is being taken. This fills bubbles while the
	// output waits.
	// ------------------------------------------------------------------
	logic            v_s1, v_s2, v_s3, v_s19;
	logic [QW-1:0]   v_s4;	// divider stages 4 .. 3+QW
	logic [N_ST-1:0] vld_all;
	logic [N_ST-1:0] adv;

	always_comb begin
		vld_all = {v_s19, v_s4, v_s3, v_s2, v_s1};
		for (int i = 0; i < N_ST; i++) begin
			adv[i] = out_ready || (|((~vld_all) >> i));
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_s19;

	// ------------------------------------------------------------------
	// Stage 1: take magnitudes and output signs. The most negative code
	// maps to 2^23 in the unsigned magnitude.
	// ------------------------------------------------------------------
	logic [SPD_W-1:0] al_s1, ar_s1;
	logic             nl_s1, nr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv[0]) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			al_s1 <= left_speed[SPD_W-1]  ? SPD_W'(-left_speed)  : SPD_W'(left_speed);
			ar_s1 <= right_speed[SPD_W-1] ? SPD_W'(-right_speed) : SPD_W'(right_speed);
			nl_s1 <= left_speed[SPD_W-1]  ^ linv_q;
			nr_s1 <= right_speed[SPD_W-1] ^ rinv_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: rpm magnitudes |speed| * gear * K, and the divider operands.
	// Scaled by max/peak and rounded, the smaller wheel is
	// floor((2*a_min*max + a_peak) / (2*a_peak)); the gear and K cancel.
	// ------------------------------------------------------------------
	logic [M_W-1:0]   ml_s2, mr_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	logic             nl_s2, nr_s2, lpk_s2, azl_s2, azr_s2;
	logic             lpk_c;
	logic [SPD_W-1:0] apk_c, amn_c;

	assign lpk_c = al_s1 >= ar_s1;
	assign apk_c = lpk_c ? al_s1 : ar_s1;
	assign amn_c = lpk_c ? ar_s1 : al_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv[1]) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && v_s1) begin
			ml_s2  <= M_W'(al_s1) * M_W'(gk_q);
			mr_s2  <= M_W'(ar_s1) * M_W'(gk_q);
			num_s2 <= {(NUM_W-1)'(amn_c) * (NUM_W-1)'(max_q), 1'b0} + NUM_W'(apk_c);
			den_s2 <= {apk_c, 1'b0};
			nl_s2  <= nl_s1;
			nr_s2  <= nr_s1;
			lpk_s2 <= lpk_c;
			azl_s2 <= al_s1 != '0;
			azr_s2 <= ar_s1 != '0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: compare the peak with the limit and round the unscaled
	// magnitudes. When scaled, the peak wheel lands exactly on max_rpm
	// and the other wheel takes the divider quotient.
	// ------------------------------------------------------------------
	pipe_t           pl_s3;
	div_t            dv_s3;
	logic [M_W-1:0]  lim_c, mpk_c;
	logic [SUMW-1:0] sum_l_c, sum_r_c;
	logic            scl_c;

	assign lim_c   = M_W'(max_q) << FR;
	assign mpk_c   = lpk_s2 ? ml_s2 : mr_s2;
	assign scl_c   = mpk_c > lim_c;
	assign sum_l_c = SUMW'(ml_s2) + HALF;
	assign sum_r_c = SUMW'(mr_s2) + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv[2]) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2] && v_s2) begin
			pl_s3.neg_l  <= nl_s2;
			pl_s3.neg_r  <= nr_s2;
			pl_s3.nz_l   <= scl_c ? (azl_s2 && max_q != '0) : (ml_s2 != '0);
			pl_s3.nz_r   <= scl_c ? (azr_s2 && max_q != '0) : (mr_s2 != '0);
			pl_s3.useq_l <= scl_c && !lpk_s2;
			pl_s3.useq_r <= scl_c && lpk_s2;
			pl_s3.scaled <= scl_c;
			pl_s3.mag_l  <= scl_c ? max_q : sum_l_c[FR +: LIM_W];
			pl_s3.mag_r  <= scl_c ? max_q : sum_r_c[FR +: LIM_W];
			dv_s3.rem    <= num_s2;
			dv_s3.den    <= den_s2;
			dv_s3.q      <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 .. 3+QW: restoring divide, one quotient bit per stage,
	// most significant bit first.
	// ------------------------------------------------------------------
	pipe_t pl_s4 [QW];
	div_t  dv_s4 [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		div_t             din;
		pipe_t            pin;
		logic             vin;
		logic [NUM_W-1:0] sh;

		if (k == 0) begin : g_first
			assign din = dv_s3;
			assign pin = pl_s3;
			assign vin = v_s3;
		end else begin : g_next
			assign din = dv_s4[k-1];
			assign pin = pl_s4[k-1];
			assign vin = v_s4[k-1];
		end

		assign sh = NUM_W'(din.den) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[k] <= 1'b0;
			end else if (adv[3+k]) begin
				v_s4[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[3+k] && vin) begin
				pl_s4[k]     <= pin;
				dv_s4[k].den <= din.den;
				if (din.rem >= sh) begin
					dv_s4[k].rem <= din.rem - sh;
					dv_s4[k].q   <= din.q | (QW'(1) << B);
				end else begin
					dv_s4[k].rem <= din.rem;
					dv_s4[k].q   <= din.q;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: pick the quotient, raise nonzero magnitudes below
	// min_rpm to min_rpm, apply the sign. Rounding up never passes
	// min_rpm, so the deadband reduces to a max against min_rpm.
	// ------------------------------------------------------------------
	pipe_t             plf_c;
	logic [QW-1:0]     qf_c;
	logic [LIM_W-1:0]  mag_l_c, mag_r_c, fin_l_c, fin_r_c;
	logic [RPM_W-1:0]  rpm_l_c, rpm_r_c;
	logic [RPM_W-1:0]  lrpm_s19, rrpm_s19;
	logic              scl_s19;

	always_comb begin
		plf_c   = pl_s4[QW-1];
		qf_c    = dv_s4[QW-1].q;
		mag_l_c = plf_c.useq_l ? qf_c : plf_c.mag_l;
		mag_r_c = plf_c.useq_r ? qf_c : plf_c.mag_r;
		fin_l_c = (plf_c.nz_l && mag_l_c < min_q) ? min_q : mag_l_c;
		fin_r_c = (plf_c.nz_r && mag_r_c < min_q) ? min_q : mag_r_c;
		rpm_l_c = (plf_c.neg_l && fin_l_c != '0) ? RPM_W'(0) - RPM_W'(fin_l_c)
		                                         : RPM_W'(fin_l_c);
		rpm_r_c = (plf_c.neg_r && fin_r_c != '0) ? RPM_W'(0) - RPM_W'(fin_r_c)
		                                         : RPM_W'(fin_r_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s19 <= 1'b0;
		end else if (adv[N_ST-1]) begin
			v_s19 <= v_s4[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[N_ST-1] && v_s4[QW-1]) begin
			lrpm_s19 <= rpm_l_c;
			rrpm_s19 <= rpm_r_c;
			scl_s19  <= plf_c.scaled;
		end
	end

	assign left_cmd   = lrpm_s19;
	assign right_cmd  = rrpm_s19;
	assign was_scaled = scl_s19;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Input is held off only when every stage is full and the output stalls.
	`WSRPM_ASSERT_IMPL(a_hold_only_full, !in_ready, out_valid && !out_ready, "input held off with room in pipe")
	// The divide must leave a remainder below the divisor.
	`WSRPM_ASSERT_IMPL(a_div_rem, v_s4[QW-1] && dv_s4[QW-1].den != '0, dv_s4[QW-1].rem < NUM_W'(dv_s4[QW-1].den), "divider remainder not reduced")
	// A scaled item routes the quotient to exactly one wheel.
	`WSRPM_ASSERT_ALWAYS(a_quot_route, !v_s3 || (pl_s3.scaled == (pl_s3.useq_l ^ pl_s3.useq_r)), "quotient routing mismatch")

endmodule

// ===== dv/wsrpm_rpm_checker.sv =====
// Checker for the wheel speed to motor rpm limiter: watches both data channels and the
// register port, predicts each rpm pair and compares it with the block's result.
// Depends on wsrpm_pkg for widths, register indexes and reset values.
`timescale 1ns / 100ps

module wsrpm_rpm_checker #(
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic signed [wsrpm_pkg::SPD_W-1:0]   left_speed,
	input  logic signed [wsrpm_pkg::SPD_W-1:0]   right_speed,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [wsrpm_pkg::RPM_W-1:0]   left_cmd,
	input  logic signed [wsrpm_pkg::RPM_W-1:0]   right_cmd,
	input  logic                                 was_scaled,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [wsrpm_pkg::ADDR_W-1:0]         paddr,
	input  logic [wsrpm_pkg::DATA_W-1:0]         pwdata,
	input  logic                                 pready,
	output int                                   mismatches,
	output int                                   pending,
	output int                                   checked
);
	import wsrpm_pkg::*;

	// fraction bits of a magnitude: speed, gear ratio and the rpm constant together
	localparam int TF = SPEED_FRAC_BITS + GEAR_FRAC + K_FRAC;

	typedef struct packed {
		logic signed [RPM_W-1:0] left;
		logic signed [RPM_W-1:0] right;
		logic                    scaled;
	} rpm_pair_t;

	logic [GEAR_W-1:0] gear_set_q;
	logic [LIM_W-1:0]  max_rpm_q;
	logic [LIM_W-1:0]  min_rpm_q;
	logic              left_inv_q;
	logic              right_inv_q;

	rpm_pair_t pending_rpm_q[$];
	int        fail_cnt = 0;
	int        done_cnt = 0;

	function automatic logic [63:0] wheel_mag(input logic [SPD_W-1:0] spd);
		logic [SPD_W-1:0] a;
		a = spd[SPD_W-1] ? -spd : spd;
		return 64'(a) * 64'(gear_set_q) * 64'(RPM_K);
	endfunction

	function automatic logic [63:0] raise_to_floor(input logic [63:0] m);
		logic [63:0] fl;
		fl = 64'(min_rpm_q) << TF;
		if (m != 0 && min_rpm_q != 0 && m < fl)
			return fl;
		return m;
	endfunction

	function automatic logic signed [RPM_W-1:0] round_rpm(input logic [63:0] m, input logic neg);
		logic [63:0] mag;
		mag = (m + (64'd1 << (TF - 1))) >> TF;
		if (mag > 64'd32767)
			mag = 64'd32767;
		return neg ? RPM_W'(-mag) : RPM_W'(mag);
	endfunction

	function automatic rpm_pair_t limit_wheel_rpm(input logic [SPD_W-1:0] ls,
		input logic [SPD_W-1:0] rs);
		logic [63:0]  ml;
		logic [63:0]  mr;
		logic [63:0]  lim;
		logic [63:0]  peak;
		logic [127:0] wide;
		rpm_pair_t    res;
		ml = wheel_mag(ls);
		mr = wheel_mag(rs);
		lim = 64'(max_rpm_q) << TF;
		peak = (ml > mr) ? ml : mr;
		res.scaled = peak > lim;
		if (res.scaled) begin
			wide = 128'(ml) * 128'(lim);
			ml = 64'(wide / 128'(peak));
			wide = 128'(mr) * 128'(lim);
			mr = 64'(wide / 128'(peak));
		end
		res.left  = round_rpm(raise_to_floor(ml), ls[SPD_W-1] ^ left_inv_q);
		res.right = round_rpm(raise_to_floor(mr), rs[SPD_W-1] ^ right_inv_q);
		return res;
	endfunction

	// print one line, count it
	task automatic flag_rpm_mismatch(input string msg);
		$display("rpm check, result %0d: %s", done_cnt, msg);
		fail_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rpm_pair_t want;
		if (!arst_n) begin
			gear_set_q   = GEAR_RST;
			max_rpm_q    = MAX_RST;
			min_rpm_q    = MIN_RST;
			left_inv_q   = 1'b0;
			right_inv_q  = 1'b0;
			pending_rpm_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_GEAR: gear_set_q   = pwdata[GEAR_W-1:0];
					REG_MAX:  max_rpm_q    = pwdata[LIM_W-1:0];
					REG_MIN:  min_rpm_q    = pwdata[LIM_W-1:0];
					REG_LINV: left_inv_q   = pwdata[0];
					REG_RINV: right_inv_q  = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_rpm_q.size() == 0) begin
					flag_rpm_mismatch("result with no speed pair waiting");
				end else begin
					want = pending_rpm_q.pop_front();
					if (left_cmd !== want.left)
						flag_rpm_mismatch($sformatf("left_cmd %0d, expected %0d",
							left_cmd, want.left));
					if (right_cmd !== want.right)
						flag_rpm_mismatch($sformatf("right_cmd %0d, expected %0d",
							right_cmd, want.right));
					if (was_scaled !== want.scaled)
						flag_rpm_mismatch($sformatf("was_scaled %0b, expected %0b",
							was_scaled, want.scaled));
					done_cnt++;
				end
			end
			if (in_valid && in_ready)
				pending_rpm_q.push_back(limit_wheel_rpm(left_speed, right_speed));
			pending    <= pending_rpm_q.size();
			mismatches <= fail_cnt;
			checked    <= done_cnt;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the rpm limiter testbench: clock, reset, speed pair and register stimulus,
// output back-pressure and the verdict. Uses wsrpm_pkg, the block and wsrpm_rpm_checker.
`timescale 1ns / 100ps

module tb_top;
	import wsrpm_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int HOLD_CYCLES = 300;	// long output stall, enough to fill every stage
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 80;
	localparam int DRAIN_WAIT  = 40;	// idle wait after the drain, for any stray result
	localparam int CYCLE_LIMIT = 100000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SPD_W-1:0] left_speed = '0;
	logic signed [SPD_W-1:0] right_speed = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [RPM_W-1:0] left_cmd;
	logic signed [RPM_W-1:0] right_cmd;
	logic                    was_scaled;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	int mismatches;
	int pending;
	int checked;
	int sent = 0;
	int settings = 0;
	int cycle_cnt = 0;

	// idle controls for the sender and the receiver
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int hold_request = 0;
	int hold_served = 0;
	int hold_left = 0;

	wheel_speed_to_motor_rpm_limiter_unit #(
		.SPEED_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_cmd(left_cmd),
		.right_cmd(right_cmd),
		.was_scaled(was_scaled),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	wsrpm_rpm_checker #(
		.SPEED_FRAC_BITS(FRAC_BITS)
	) rpm_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_cmd(left_cmd),
		.right_cmd(right_cmd),
		.was_scaled(was_scaled),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run if it reaches the cycle limit, whether or not the block still moves.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d rpm results outstanding",
				cycle_cnt, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: drop out_ready at random, hold it high in the steady stretch, and
	// hold it low through a stall when the stimulus asks for one. The stall is
	// counted here so the sender keeps offering transfers meanwhile.
	always begin
		@(posedge clk);
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_served != hold_request) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 6);
		end
	end

	// Mix of zero, the two extremes, tiny values near the deadband, mid-range
	// values and full-range noise; every bit of the field toggles.
	function automatic logic [SPD_W-1:0] pick_speed();
		logic [SPD_W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = 24'h7FFFFF;
			2: v = 24'h800000;
			3, 4: begin
				v = SPD_W'($urandom_range(600));
				if ($urandom_range(1))
					v = -v;
			end
			5: begin
				v = SPD_W'($urandom_range(1 << 18));
				if ($urandom_range(1))
					v = -v;
			end
			default: v = SPD_W'($urandom());
		endcase
		return v;
	endfunction

	// Offer one speed pair and return at the edge where it transfers. Valid stays
	// high for a back-to-back pair; outside the steady phases a random gap lowers it first.
	task automatic send_pair(input logic [SPD_W-1:0] l, input logic [SPD_W-1:0] r);
		if (!tx_steady && $urandom_range(99) < 3) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		left_speed  <= l;
		right_speed <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// Stop offering and wait until every predicted rpm pair has come out.
	// The first edge lets the checker count the last transfer.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Write all five registers, each with a setup and an access phase. psel stays
	// high across the writes so no signal is lowered and raised in one step.
	task automatic write_settings(input int gear, input int max_lim, input int min_lim,
		input bit linv, input bit rinv);
		logic [DATA_W-1:0] vals [5];
		logic [2:0]        idx [5];
		vals = '{DATA_W'(gear), DATA_W'(max_lim), DATA_W'(min_lim),
			DATA_W'(linv), DATA_W'(rinv)};
		idx  = '{REG_GEAR, REG_MAX, REG_MIN, REG_LINV, REG_RINV};
		for (int i = 0; i < 5; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {idx[i], 2'b00};
			pwdata  <= vals[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings++;
	endtask

	initial begin
		int g;
		int mx;
		int mn;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: unit gear, no scaling reachable, deadband off.
		send_pair(24'h000000, 24'h000000);
		send_pair(24'h7FFFFF, 24'h800000);
		send_pair(24'h800000, 24'h800000);
		send_pair(24'h000001, 24'hFFFFFF);
		send_pair(24'h1A2B3C, 24'hE5D4C3);

		// Largest gear: fast pairs scale to the limit with the ratio kept; left inverted.
		settle();
		write_settings(65535, 32767, 0, 1'b1, 1'b0);
		send_pair(24'h7FFFFF, 24'h7FFFFF);
		send_pair(24'h800000, 24'h000001);
		send_pair(24'h7FFFFF, 24'h400000);
		send_pair(24'h000000, 24'h800000);
		send_pair(24'hFFFFFF, 24'h000000);

		// Minimum above maximum: limit first, then raise to the minimum.
		settle();
		write_settings(1, 1, 32767, 1'b0, 1'b1);
		send_pair(24'h000001, 24'hFFFFFF);
		send_pair(24'h000000, 24'h7FFFFF);
		send_pair(24'h800000, 24'h7FFFFF);

		// Zero gear ratio: all outputs zero, deadband not applied.
		settle();
		write_settings(0, 3000, 50, 1'b1, 1'b0);
		send_pair(24'h7FFFFF, 24'h800000);
		send_pair(24'h000001, 24'h000000);

		// Zero limit: every nonzero speed scales to zero and stays there.
		settle();
		write_settings(256, 0, 50, 1'b0, 1'b1);
		send_pair(24'h000100, 24'hFFFF00);
		send_pair(24'h000000, 24'h000001);
		send_pair(24'h7FFFFF, 24'h000000);

		// Scaled then raised: the small wheel comes out at the minimum.
		settle();
		write_settings(4096, 500, 600, 1'b1, 1'b1);
		send_pair(24'h7FFFFF, 24'h000001);
		send_pair(24'h800000, 24'hFFF000);

		// Random phases, each under fresh settings. Phase 3 runs with no idling on
		// either side; phase 6 sends back to back into a long output stall.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: write_settings(65535, 32767, 0, 1'b1, 1'b1);
				1: write_settings(1, 1, 32767, 1'b0, 1'b0);
				default: begin
					case ($urandom_range(3))
						0: g = 1;
						1: g = 65535;
						2: g = 256;
						default: g = $urandom_range(1, 65535);
					endcase
					case ($urandom_range(3))
						0: mx = 1;
						1: mx = 32767;
						2: mx = $urandom_range(1, 4000);
						default: mx = $urandom_range(1, 32767);
					endcase
					case ($urandom_range(3))
						0: mn = 0;
						1: mn = $urandom_range(1, 200);
						2: mn = $urandom_range(0, 32767);
						default: mn = 0;
					endcase
					write_settings(g, mx, mn, 1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			endcase
			tx_steady = (ph == 3 || ph == 6);
			rx_steady = (ph == 3);
			if (ph == 6)
				hold_request++;
			repeat (PHASE_ITEMS)
				send_pair(pick_speed(), pick_speed());
		end

		// Drain, then give the block time to show any stray result.
		settle();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d rpm results from %0d speed pairs under %0d register settings,",
			checked, sent, settings);
		$display("with random stalls on both sides, a no-idle stretch and a %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
